// ===== design/lru_eviction_with_pinning_assert.svh =====
// Assertion macros shared by the RTL of the LRU replacement table.
// Needs signals named clk and rst_n in the including module.
`ifndef LRU_EVICTION_WITH_PINNING_ASSERT_SVH
`define LRU_EVICTION_WITH_PINNING_ASSERT_SVH
// Checks a property on every rising edge outside of reset.
`define LRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks an implication on every rising edge outside of reset.
`define LRU_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

// ===== design/lru_pkg.sv =====
// Package for the LRU replacement table with pinning.
// Holds operation, status and register codes and default sizes.
package lru_pkg;
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 64;

  localparam logic [2:0] MODE_ACCESS = 3'd0;
  localparam logic [2:0] MODE_PIN    = 3'd1;
  localparam logic [2:0] MODE_UNPIN  = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_ADJUST = 3'd4;
  localparam logic [2:0] MODE_SELECT = 3'd5;
  localparam logic [2:0] MODE_STATUS = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [1:0] CFG_WATERMARK = 2'd1;
  localparam logic [1:0] CFG_RATIO     = 2'd2;

  localparam logic [16:0] WATERMARK_RST = 17'd58982;
  localparam logic [16:0] RATIO_RST     = 17'd13107;
endpackage

// ===== design/lru_in_if.sv =====
// Input channel of the LRU replacement table: valid, ready and one item.
// No dependencies.
interface lru_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [63:0]        block_id;
  logic [31:0]        block_size;
  logic signed [31:0] size_delta;

  modport source (output valid, mode, block_id, block_size, size_delta, input ready);
  modport sink (input valid, mode, block_id, block_size, size_delta, output ready);
endinterface

// ===== design/lru_out_if.sv =====
// Result channel of the LRU replacement table: valid, ready and one item.
// No dependencies.
interface lru_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        candidate_valid;
  logic [63:0] candidate_id;
  logic        last;
  logic        should_evict;
  logic [47:0] current_bytes;
  logic [6:0]  block_count;
  logic [31:0] eviction_count;
  logic [47:0] evicted_bytes_total;

  modport source (output valid, status, candidate_valid, candidate_id, last, should_evict,
                  current_bytes, block_count, eviction_count, evicted_bytes_total,
                  input ready);
  modport sink (input valid, status, candidate_valid, candidate_id, last, should_evict,
                current_bytes, block_count, eviction_count, evicted_bytes_total,
                output ready);
endinterface

// ===== design/lru_eviction_with_pinning.sv =====
// LRU replacement table with pinning. Every item first scans all ENTRIES slots of the
// table memory one per cycle, then access and remove sweep ages over the table again;
// select sweeps an age index and walks candidates through S_SELA, S_SELB and S_SELC.
// The table takes one item at a time.
// A configuration write starts a threshold recompute on the shared multiplier.
// Synchronous reset empties the table; the thresholds are recomputed after reset.
module lru_eviction_with_pinning
  import lru_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  lru_in_if.sink      in_ch,
  lru_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [47:0] cfg_wdata
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = KEY_BITS + 32 + IW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CALC  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_AGE   = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_ORD   = 4'd6;
  localparam logic [3:0] S_SELA  = 4'd7;
  localparam logic [3:0] S_SELB  = 4'd8;
  localparam logic [3:0] S_SELC  = 4'd9;
  localparam logic [3:0] S_SELE  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]          state_r, state_nxt;
  logic                dirty_r;
  logic [2:0]          cstep_r;
  logic [47:0]         cap_r;
  logic [16:0]         wm_r, ratio_r;
  logic [48:0]         prod_r, qh_r, th_r;
  logic [49:0]         q_r, target_r;
  logic [31:0]         mul_a;
  logic [16:0]         mul_b;

  logic [ENTRIES-1:0]  valid_r, pin_r;
  logic [CW-1:0]       cnt_r;
  logic [47:0]         total_r, evb_r;
  logic [31:0]         evc_r;

  logic [MW-1:0]       mem [ENTRIES];
  logic [IW-1:0]       ord_mem [ENTRIES];
  logic [MW-1:0]       rd_q_r;
  logic [IW-1:0]       ord_q_r;
  logic [IW-1:0]       rd_addr, mem_wa, ord_wa, ord_wd;
  logic [MW-1:0]       mem_wd;
  logic                mem_we, ord_we;

  logic [IW-1:0]       idx_r, pidx_r, slot_r, fslot_r, a_r;
  logic                iss_r, pv_r, found_r, free_r, sweep_end;
  logic [IW-1:0]       oage_r;
  logic [31:0]         obytes_r;
  logic [2:0]          mode_r;
  logic [KEY_BITS-1:0] key_r, pend_r;
  logic [31:0]         size_r, delta_r;
  logic [1:0]          st_r;
  logic                pend_v_r;
  logic [49:0]         sum_r;

  logic [KEY_BITS-1:0] rk;
  logic [31:0]         rb;
  logic [IW-1:0]       ra, age_new;
  logic                can_push, push, push_cv, push_last, sel_take, sel_next;
  logic [63:0]         push_id;
  logic                should_evict;
  logic [48:0]         add_size, add_delta, add_rm;
  logic [32:0]         mag;

  assign rk = rd_q_r[MW-1 -: KEY_BITS];
  assign rb = rd_q_r[IW+31:IW];
  assign ra = rd_q_r[IW-1:0];
  assign sweep_end = pv_r && !iss_r && (pidx_r == IW'(ENTRIES - 1));
  assign can_push = !out_ch.valid || out_ch.ready;
  assign should_evict = (cap_r != 48'd0) && ({2'b00, total_r} >= q_r);
  assign in_ch.ready = (state_r == S_IDLE) && !dirty_r;
  assign add_size = {1'b0, total_r} + {17'd0, size_r};
  assign add_delta = {1'b0, total_r} + {17'd0, delta_r};
  assign add_rm = {1'b0, evb_r} + {17'd0, obytes_r};
  assign mag = {1'b0, ~delta_r} + 33'd1;
  assign sel_take = !pin_r[slot_r] && (!pend_v_r || can_push);
  assign sel_next = pin_r[slot_r] || sel_take;

  always_comb begin
    unique case (cstep_r)
      3'd0: begin mul_a = cap_r[47:16]; mul_b = wm_r; end
      3'd1: begin mul_a = {16'd0, cap_r[15:0]}; mul_b = wm_r; end
      3'd2: begin mul_a = cap_r[47:16]; mul_b = ratio_r; end
      default: begin mul_a = {16'd0, cap_r[15:0]}; mul_b = ratio_r; end
    endcase
  end

  always_comb begin
    unique case (mode_r)
      MODE_ACCESS: age_new = found_r ? ((ra < oage_r) ? ra + 1'b1 : ra) : ra + 1'b1;
      MODE_REMOVE: age_new = (ra > oage_r) ? ra - 1'b1 : ra;
      default:     age_new = ra;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    rd_addr   = idx_r;
    mem_we    = 1'b0;
    mem_wa    = pidx_r;
    mem_wd    = {rk, rb, age_new};
    ord_we    = 1'b0;
    ord_wa    = ra;
    ord_wd    = pidx_r;
    push      = 1'b0;
    push_cv   = 1'b0;
    push_id   = 64'd0;
    push_last = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (dirty_r) begin
          state_nxt = S_CALC;
        end else if (in_ch.valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_CALC: begin
        if (cstep_r == 3'd4) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (sweep_end) state_nxt = S_DEC;
      end
      S_DEC: begin
        unique case (mode_r)
          MODE_ACCESS: state_nxt = (found_r || free_r) ? S_AGE : S_OUT;
          MODE_REMOVE: state_nxt = found_r ? S_AGE : S_OUT;
          MODE_SELECT: state_nxt = S_ORD;
          default:     state_nxt = S_OUT;
        endcase
      end
      S_AGE: begin
        mem_we = pv_r && valid_r[pidx_r];
        if (sweep_end) state_nxt = S_FIN;
      end
      S_FIN: begin
        mem_we = (mode_r == MODE_ACCESS);
        mem_wa = found_r ? slot_r : fslot_r;
        mem_wd = {key_r, found_r ? obytes_r : size_r, {IW{1'b0}}};
        state_nxt = S_OUT;
      end
      S_ORD: begin
        ord_we = pv_r && valid_r[pidx_r];
        if (sweep_end) state_nxt = (cnt_r == '0) ? S_SELE : S_SELA;
      end
      S_SELA: begin
        state_nxt = (sum_r >= target_r) ? S_SELE : S_SELB;
      end
      S_SELB: begin
        rd_addr = ord_q_r;
        state_nxt = S_SELC;
      end
      S_SELC: begin
        rd_addr = slot_r;
        if (sel_take && pend_v_r) begin
          push      = 1'b1;
          push_cv   = 1'b1;
          push_id   = 64'(pend_r);
          push_last = 1'b0;
        end
        if (sel_next) state_nxt = (a_r == '0) ? S_SELE : S_SELA;
      end
      S_SELE: begin
        if (can_push) begin
          push      = 1'b1;
          push_cv   = pend_v_r;
          push_id   = pend_v_r ? 64'(pend_r) : 64'd0;
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (can_push) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q_r <= mem[rd_addr];
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_q_r <= ord_mem[a_r];
    prod_r <= 49'(mul_a) * 49'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      dirty_r    <= 1'b1;
      cstep_r    <= 3'd0;
      cap_r      <= 48'd0;
      wm_r       <= WATERMARK_RST;
      ratio_r    <= RATIO_RST;
      valid_r    <= '0;
      pin_r      <= '0;
      cnt_r      <= '0;
      total_r    <= 48'd0;
      evb_r      <= 48'd0;
      evc_r      <= 32'd0;
      iss_r      <= 1'b0;
      pv_r       <= 1'b0;
      pend_v_r   <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= 1'b0;
      if (cfg_we) begin
        dirty_r <= 1'b1;
        priority case (cfg_idx)
          CFG_CAPACITY:  cap_r   <= cfg_wdata;
          CFG_WATERMARK: wm_r    <= cfg_wdata[16:0];
          CFG_RATIO:     ratio_r <= cfg_wdata[16:0];
          default: ;
        endcase
      end
      if ((state_r == S_SCAN || state_r == S_AGE || state_r == S_ORD) && iss_r) begin
        pv_r   <= 1'b1;
        pidx_r <= idx_r;
        if (idx_r == IW'(ENTRIES - 1)) iss_r <= 1'b0;
        else idx_r <= idx_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!dirty_r && in_ch.valid) begin
            mode_r  <= in_ch.mode;
            key_r   <= in_ch.block_id[KEY_BITS-1:0];
            size_r  <= in_ch.block_size;
            delta_r <= in_ch.size_delta;
            idx_r   <= '0;
            iss_r   <= 1'b1;
            found_r <= 1'b0;
            free_r  <= 1'b0;
            st_r    <= ST_OK;
          end
        end
        S_CALC: begin
          cstep_r <= cstep_r + 3'd1;
          unique case (cstep_r)
            3'd1: qh_r <= prod_r;
            3'd2: q_r <= 50'(qh_r) + 50'(prod_r[48:16]) + 50'(prod_r[15:0] != 16'd0);
            3'd3: th_r <= prod_r;
            3'd4: begin
              target_r <= 50'(th_r) + 50'(prod_r[48:16]);
              cstep_r  <= 3'd0;
              dirty_r  <= cfg_we;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (pv_r) begin
            if (valid_r[pidx_r] && rk == key_r && !found_r) begin
              found_r  <= 1'b1;
              slot_r   <= pidx_r;
              oage_r   <= ra;
              obytes_r <= rb;
            end
            if (!valid_r[pidx_r] && !free_r) begin
              free_r  <= 1'b1;
              fslot_r <= pidx_r;
            end
          end
        end
        S_DEC: begin
          idx_r <= '0;
          iss_r <= 1'b1;
          unique case (mode_r)
            MODE_ACCESS: begin
              if (!found_r && !free_r) st_r <= ST_FULL;
            end
            MODE_PIN, MODE_UNPIN: begin
              if (found_r) pin_r[slot_r] <= (mode_r == MODE_PIN);
              else st_r <= ST_NOTFOUND;
            end
            MODE_REMOVE: begin
              if (found_r) begin
                total_r <= (total_r < {16'd0, obytes_r}) ? 48'd0 : total_r - {16'd0, obytes_r};
                evb_r   <= add_rm[48] ? {48{1'b1}} : add_rm[47:0];
                evc_r   <= evc_r + 32'd1;
                valid_r[slot_r] <= 1'b0;
                pin_r[slot_r]   <= 1'b0;
                cnt_r   <= cnt_r - 1'b1;
              end else begin
                st_r <= ST_NOTFOUND;
              end
            end
            MODE_ADJUST: begin
              if (delta_r[31]) begin
                total_r <= ({15'd0, mag} > total_r) ? 48'd0 : total_r - {15'd0, mag};
              end else begin
                total_r <= add_delta[48] ? {48{1'b1}} : add_delta[47:0];
              end
            end
            MODE_SELECT: begin
              a_r      <= IW'(cnt_r - 1'b1);
              sum_r    <= 50'd0;
              pend_v_r <= 1'b0;
            end
            default: ;
          endcase
        end
        S_FIN: begin
          if (mode_r == MODE_ACCESS && !found_r) begin
            valid_r[fslot_r] <= 1'b1;
            pin_r[fslot_r]   <= 1'b0;
            cnt_r   <= cnt_r + 1'b1;
            total_r <= add_size[48] ? {48{1'b1}} : add_size[47:0];
          end
        end
        S_SELB: slot_r <= ord_q_r;
        S_SELC: begin
          if (sel_take) begin
            pend_r   <= rk;
            pend_v_r <= 1'b1;
            sum_r    <= sum_r + 50'(rb);
          end
          if (sel_next && a_r != '0) a_r <= a_r - 1'b1;
        end
        default: ;
      endcase
      if (push) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_ch.status              <= push_cv ? ST_OK : st_r;
      out_ch.candidate_valid     <= push_cv;
      out_ch.candidate_id        <= push_id;
      out_ch.last                <= push_last;
      out_ch.should_evict        <= should_evict;
      out_ch.current_bytes       <= total_r;
      out_ch.block_count         <= 7'(cnt_r);
      out_ch.eviction_count      <= evc_r;
      out_ch.evicted_bytes_total <= evb_r;
    end
  end

`include "lru_eviction_with_pinning_assert.svh"
  `LRU_ASSERT(a_count_matches, cnt_r == CW'($countones(valid_r)), "block count mismatch")
  `LRU_ASSERT(a_pin_on_valid, (pin_r & ~valid_r) == '0, "pinned slot not valid")
  `LRU_ASSERT_IMP(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "second item taken")
endmodule
